FILE: hdl/ped_pkg.sv
// ped_pkg: shared types and constants for the percent escape decoder
// holds the output run record passed from the decode core to the top level
// no dependencies

package ped_pkg;

    // most output bytes one input request can cause
    localparam int RUN_MAX = 6;
    localparam int CNT_W   = 3;

    typedef logic [7:0] byte_t;
    typedef logic [CNT_W-1:0] cnt_t;

    // bytes produced by one request, in order, and how many are valid
    typedef struct packed {
        byte_t [RUN_MAX-1:0] bytes;
        cnt_t                count;
    } run_t;

    // append one byte to a run, ignoring overflow past RUN_MAX
    function automatic run_t run_push(run_t r, byte_t b);
        run_t res;
        res = r;
        if (r.count < cnt_t'(RUN_MAX))
        begin
            res.bytes[r.count] = b;
            res.count          = r.count + cnt_t'(1);
        end
        return res;
    endfunction

endpackage

FILE: hdl/percent_escape_decoder_unit.sv
// the first output byte of a request is valid in the cycle after acceptance
// throughput: one request per cycle while each causes at most one byte and the receiver
// is ready; a request causing more bytes holds the input until its last byte is taken
// reset: scanner returns to idle with nothing held, output run register empties
// depends on ped_pkg and ped_core

module percent_escape_decoder_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       end_of_stream,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       last_of_run
);

    ped_pkg::run_t                         run;
    ped_pkg::byte_t [ped_pkg::RUN_MAX-1:0] buf_reg, buf_next;
    ped_pkg::cnt_t                         cnt_reg, cnt_next;
    logic                                  in_fire, out_fire;

    // take a request when the run register is empty or about to empty
    assign in_ready = (cnt_reg == '0) || (cnt_reg == ped_pkg::cnt_t'(1) && out_ready);
    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid && out_ready;

    ped_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (in_fire),
        .in_byte       (in_byte),
        .end_of_stream (end_of_stream),
        .run           (run)
    );

    // run register: load a new run, or shift one byte out
    always_comb
    begin
        buf_next = buf_reg;
        cnt_next = cnt_reg;
        if (in_fire && run.count != '0)
        begin
            buf_next = run.bytes;
            cnt_next = run.count;
        end
        else if (out_fire)
        begin
            for (int i = 0; i < ped_pkg::RUN_MAX - 1; i++)
                buf_next[i] = buf_reg[i+1];
            cnt_next = cnt_reg - ped_pkg::cnt_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
    end

    assign out_valid   = (cnt_reg != '0);
    assign out_byte    = buf_reg[0];
    assign last_of_run = (cnt_reg == ped_pkg::cnt_t'(1));

    // checks
    a_run_shows: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && run.count != '0) |=> (out_valid && cnt_reg == $past(run.count)))
        else $error("loaded run not presented");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= ped_pkg::cnt_t'(ped_pkg::RUN_MAX))
        else $error("run count beyond maximum");

    a_last_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && last_of_run && !in_fire) |=> !out_valid)
        else $error("output still valid after last byte of run");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && out_valid) |-> (last_of_run && out_ready))
        else $error("request accepted over undelivered bytes");

endmodule

FILE: hdl/ped_core.sv
// ped_core: escape scanning state machine and per-request run builder
// depends on ped_pkg for run_t and run_push

module ped_core (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           accept,
    input  logic [7:0]     in_byte,
    input  logic           end_of_stream,
    output ped_pkg::run_t  run
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_PCT,
        PH_DIG,
        PH_CR,
        PH_CR_PCT,
        PH_CR_DIG
    } phase_t;

    localparam ped_pkg::byte_t CH_PCT = 8'h25;
    localparam ped_pkg::byte_t CH_CR  = 8'h0D;
    localparam ped_pkg::byte_t CH_LF  = 8'h0A;
    localparam ped_pkg::byte_t [5:0] BR_TEXT = {8'h3E, 8'h2F, 8'h20, 8'h72, 8'h62, 8'h3C};

    // hex digit check: {is_hex, value}, nul never counts
    function automatic logic [4:0] hex_decode(ped_pkg::byte_t b);
        logic [4:0] res;
        res = 5'b0;
        if (b >= 8'h30 && b <= 8'h39)
            res = {1'b1, b[3:0]};
        else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66))
            res = {1'b1, b[3:0] + 4'd9};
        return res;
    endfunction

    phase_t         phase_reg, phase_next, phase_mid;
    ped_pkg::byte_t held_reg, held_next;
    logic [4:0]     hv, hh;
    ped_pkg::byte_t pair;
    ped_pkg::run_t  r;

    assign hv   = hex_decode(in_byte);
    assign hh   = hex_decode(held_reg);
    assign pair = {hh[3:0], hv[3:0]};

    // byte handling, then flush of held bytes at end of stream
    always_comb
    begin
        r         = '0;
        phase_mid = PH_IDLE;
        held_next = held_reg;
        case (phase_reg)
            PH_PCT:
            begin
                if (hv[4])
                begin
                    held_next = in_byte;
                    phase_mid = PH_DIG;
                end
                else
                begin
                    r = ped_pkg::run_push(r, CH_PCT);
                    r = ped_pkg::run_push(r, in_byte);
                end
            end
            PH_DIG:
            begin
                if (hv[4])
                begin
                    if (pair == CH_CR)
                        phase_mid = PH_CR;
                    else
                        r = ped_pkg::run_push(r, pair);
                end
                else
                begin
                    r = ped_pkg::run_push(r, CH_PCT);
                    r = ped_pkg::run_push(r, held_reg);
                    r = ped_pkg::run_push(r, in_byte);
                end
            end
            PH_CR:
            begin
                if (in_byte == CH_PCT)
                    phase_mid = PH_CR_PCT;
                else
                begin
                    r = ped_pkg::run_push(r, CH_CR);
                    r = ped_pkg::run_push(r, in_byte);
                end
            end
            PH_CR_PCT:
            begin
                if (hv[4])
                begin
                    held_next = in_byte;
                    phase_mid = PH_CR_DIG;
                end
                else
                begin
                    r = ped_pkg::run_push(r, CH_CR);
                    r = ped_pkg::run_push(r, CH_PCT);
                    r = ped_pkg::run_push(r, in_byte);
                end
            end
            PH_CR_DIG:
            begin
                if (hv[4])
                begin
                    if (pair == CH_LF)
                    begin
                        r.bytes = BR_TEXT;
                        r.count = ped_pkg::cnt_t'(ped_pkg::RUN_MAX);
                    end
                    else
                    begin
                        r = ped_pkg::run_push(r, CH_CR);
                        r = ped_pkg::run_push(r, pair);
                    end
                end
                else
                begin
                    r = ped_pkg::run_push(r, CH_CR);
                    r = ped_pkg::run_push(r, CH_PCT);
                    r = ped_pkg::run_push(r, held_reg);
                    r = ped_pkg::run_push(r, in_byte);
                end
            end
            default:
            begin
                if (in_byte == CH_PCT)
                    phase_mid = PH_PCT;
                else
                    r = ped_pkg::run_push(r, in_byte);
            end
        endcase

        phase_next = phase_mid;
        if (end_of_stream)
        begin
            phase_next = PH_IDLE;
            case (phase_mid)
                PH_PCT:
                    r = ped_pkg::run_push(r, CH_PCT);
                PH_DIG:
                begin
                    r = ped_pkg::run_push(r, CH_PCT);
                    r = ped_pkg::run_push(r, held_next);
                end
                PH_CR:
                    r = ped_pkg::run_push(r, CH_CR);
                PH_CR_PCT:
                begin
                    r = ped_pkg::run_push(r, CH_CR);
                    r = ped_pkg::run_push(r, CH_PCT);
                end
                PH_CR_DIG:
                begin
                    r = ped_pkg::run_push(r, CH_CR);
                    r = ped_pkg::run_push(r, CH_PCT);
                    r = ped_pkg::run_push(r, held_next);
                end
                default:
                    ;
            endcase
        end
    end

    assign run = r;

    // scanner state, advanced once per accepted request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            held_reg  <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
        end
    end

endmodule

FILE: tb/tb_percent_escape_decoder_unit.sv
// tb_percent_escape_decoder_unit: self-checking bench for the percent escape decoder
// checks each output byte against an in-bench decoder fed with every accepted request
// depends on ped_pkg and percent_escape_decoder_unit

module tb_percent_escape_decoder_unit;

    typedef ped_pkg::byte_t byte_t;

    // scanner phases of the decoder
    typedef enum logic [2:0] {
        SCAN_IDLE   = 3'd0,
        SCAN_PCT    = 3'd1,
        SCAN_DIG    = 3'd2,
        SCAN_CR     = 3'd3,
        SCAN_CR_PCT = 3'd4,
        SCAN_CR_DIG = 3'd5
    } scan_phase_t;

    localparam byte_t PCT_CHAR = 8'h25;
    localparam byte_t CR_CHAR  = 8'h0D;
    localparam byte_t LF_CHAR  = 8'h0A;

    localparam int RANDOM_ITEMS = 210;
    localparam int MAX_REPORTS  = 10;
    localparam int DRAIN_CYCLES = 20;
    // receiver hold-off and quiet windows, in cycles after reset
    localparam int HOLD_START   = 150;
    localparam int HOLD_LEN     = 120;
    localparam int CALM_START   = 400;
    localparam int CALM_END     = 700;
    // sender window with no gaps, in accepted requests
    localparam int SEND_CALM_LO = 120;
    localparam int SEND_CALM_HI = 170;

    typedef struct {
        byte_t data;
        logic  eos;
    } pending_req_t;

    typedef struct {
        byte_t data;
        logic  last;
    } out_rec_t;

    logic       clk           = 1'b0;
    logic       rst_n         = 1'b0;
    logic       in_valid      = 1'b0;
    logic       in_ready;
    logic [7:0] in_byte       = 8'h00;
    logic       end_of_stream = 1'b0;
    logic       out_valid;
    logic       out_ready     = 1'b0;
    logic [7:0] out_byte;
    logic       last_of_run;

    pending_req_t pending_requests[$];
    out_rec_t     expected_bytes[$];
    pending_req_t next_req;
    out_rec_t     want;

    scan_phase_t scan_phase = SCAN_IDLE;
    byte_t       held_digit = 8'h00;
    int          mismatches = 0;
    int          sent_count = 0;
    int          rx_cycle   = 0;
    int          queued     = 0;

    percent_escape_decoder_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_byte       (in_byte),
        .end_of_stream (end_of_stream),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_byte      (out_byte),
        .last_of_run   (last_of_run)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // value of a hex digit, -1 for anything else (nul included)
    function automatic int hex_of(byte_t b);
        if (b >= "0" && b <= "9")
            return int'(b) - int'("0");
        if (b >= "A" && b <= "F")
            return int'(b) - int'("A") + 10;
        if (b >= "a" && b <= "f")
            return int'(b) - int'("a") + 10;
        return -1;
    endfunction

    // advance the scanner by one request and queue the bytes it should produce
    task automatic decode_request(byte_t b, logic eos);
        byte_t run[$];
        byte_t v;
        int    hv;
        hv = hex_of(b);
        case (scan_phase)
            SCAN_PCT:
            begin
                if (hv >= 0)
                begin
                    held_digit = b;
                    scan_phase = SCAN_DIG;
                end
                else
                begin
                    run.push_back(PCT_CHAR);
                    run.push_back(b);
                    scan_phase = SCAN_IDLE;
                end
            end
            SCAN_DIG:
            begin
                if (hv >= 0)
                begin
                    v = byte_t'((hex_of(held_digit) << 4) | hv);
                    if (v == CR_CHAR)
                        scan_phase = SCAN_CR;
                    else
                    begin
                        run.push_back(v);
                        scan_phase = SCAN_IDLE;
                    end
                end
                else
                begin
                    run.push_back(PCT_CHAR);
                    run.push_back(held_digit);
                    run.push_back(b);
                    scan_phase = SCAN_IDLE;
                end
            end
            SCAN_CR:
            begin
                if (b == PCT_CHAR)
                    scan_phase = SCAN_CR_PCT;
                else
                begin
                    run.push_back(CR_CHAR);
                    run.push_back(b);
                    scan_phase = SCAN_IDLE;
                end
            end
            SCAN_CR_PCT:
            begin
                if (hv >= 0)
                begin
                    held_digit = b;
                    scan_phase = SCAN_CR_DIG;
                end
                else
                begin
                    run.push_back(CR_CHAR);
                    run.push_back(PCT_CHAR);
                    run.push_back(b);
                    scan_phase = SCAN_IDLE;
                end
            end
            SCAN_CR_DIG:
            begin
                if (hv >= 0)
                begin
                    v = byte_t'((hex_of(held_digit) << 4) | hv);
                    if (v == LF_CHAR)
                    begin
                        run.push_back("<");
                        run.push_back("b");
                        run.push_back("r");
                        run.push_back(" ");
                        run.push_back("/");
                        run.push_back(">");
                    end
                    else
                    begin
                        run.push_back(CR_CHAR);
                        run.push_back(v);
                    end
                end
                else
                begin
                    run.push_back(CR_CHAR);
                    run.push_back(PCT_CHAR);
                    run.push_back(held_digit);
                    run.push_back(b);
                end
                scan_phase = SCAN_IDLE;
            end
            default:
            begin
                if (b == PCT_CHAR)
                    scan_phase = SCAN_PCT;
                else
                begin
                    run.push_back(b);
                    scan_phase = SCAN_IDLE;
                end
            end
        endcase

        // end of stream flushes whatever is held
        if (eos)
        begin
            case (scan_phase)
                SCAN_PCT:
                    run.push_back(PCT_CHAR);
                SCAN_DIG:
                begin
                    run.push_back(PCT_CHAR);
                    run.push_back(held_digit);
                end
                SCAN_CR:
                    run.push_back(CR_CHAR);
                SCAN_CR_PCT:
                begin
                    run.push_back(CR_CHAR);
                    run.push_back(PCT_CHAR);
                end
                SCAN_CR_DIG:
                begin
                    run.push_back(CR_CHAR);
                    run.push_back(PCT_CHAR);
                    run.push_back(held_digit);
                end
                default:
                    ;
            endcase
            scan_phase = SCAN_IDLE;
        end

        foreach (run[i])
            expected_bytes.push_back('{data: run[i], last: (i == run.size() - 1)});
    endtask

    task automatic queue_request(byte_t b, logic eos);
        pending_requests.push_back('{data: b, eos: eos});
        queued++;
    endtask

    // whole string as requests, end flag optionally on the final byte
    task automatic queue_text(string s, logic eos_last);
        for (int i = 0; i < s.len(); i++)
            queue_request(byte_t'(s[i]), eos_last && (i == s.len() - 1));
    endtask

    function automatic byte_t rand_hex_char();
        int n;
        n = $urandom_range(0, 15);
        if (n < 10)
            return byte_t'(int'("0") + n);
        if ($urandom_range(0, 1))
            return byte_t'(int'("a") + n - 10);
        return byte_t'(int'("A") + n - 10);
    endfunction

    function automatic byte_t rand_non_hex();
        byte_t b;
        if ($urandom_range(0, 7) == 0)
            return 8'h00;
        do
            b = byte_t'($urandom_range(0, 255));
        while (hex_of(b) >= 0);
        return b;
    endfunction

    function automatic logic rand_eos();
        return ($urandom_range(0, 24) == 0);
    endfunction

    // one random well-formed or broken fragment of the stream
    task automatic queue_fragment();
        int    pick;
        byte_t b;
        pick = $urandom_range(0, 99);
        if (pick < 28)
        begin
            do
                b = byte_t'($urandom_range(0, 255));
            while (b == PCT_CHAR);
            queue_request(b, rand_eos());
        end
        else if (pick < 48)
        begin
            queue_request(PCT_CHAR, rand_eos());
            queue_request(rand_hex_char(), rand_eos());
            queue_request(rand_hex_char(), rand_eos());
        end
        else if (pick < 62)
        begin
            // carriage return and line feed escapes back to back
            queue_request(PCT_CHAR, rand_eos());
            queue_request("0", rand_eos());
            queue_request($urandom_range(0, 1) ? "d" : "D", rand_eos());
            queue_request(PCT_CHAR, rand_eos());
            queue_request("0", rand_eos());
            queue_request($urandom_range(0, 1) ? "a" : "A", rand_eos());
        end
        else if (pick < 76)
        begin
            // carriage return escape followed by something else
            queue_request(PCT_CHAR, rand_eos());
            queue_request("0", rand_eos());
            queue_request($urandom_range(0, 1) ? "d" : "D", rand_eos());
            case ($urandom_range(0, 3))
                0: queue_request(byte_t'($urandom_range(0, 255)), rand_eos());
                1:
                begin
                    queue_request(PCT_CHAR, rand_eos());
                    queue_request(rand_non_hex(), rand_eos());
                end
                2:
                begin
                    queue_request(PCT_CHAR, rand_eos());
                    queue_request(rand_hex_char(), rand_eos());
                    queue_request(rand_non_hex(), rand_eos());
                end
                default:
                begin
                    queue_request(PCT_CHAR, rand_eos());
                    queue_request(rand_hex_char(), rand_eos());
                    queue_request(rand_hex_char(), rand_eos());
                end
            endcase
        end
        else if (pick < 90)
        begin
            // broken escapes
            queue_request(PCT_CHAR, rand_eos());
            if ($urandom_range(0, 1))
                queue_request(rand_hex_char(), rand_eos());
            queue_request(rand_non_hex(), rand_eos());
        end
        else
            queue_request(byte_t'($urandom_range(0, 255)), rand_eos());
    endtask

    task automatic report_mismatch(string what, byte_t exp_b, logic exp_l);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch (%s): expected byte %02h last %0b, got byte %02h last %0b",
                     what, exp_b, exp_l, out_byte, last_of_run);
    endtask

    // sender: offers pending requests with random gaps, holds until accepted
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                decode_request(in_byte, end_of_stream);
                sent_count++;
            end
            if (!in_valid || in_ready)
            begin
                if (pending_requests.size() > 0 &&
                    ((sent_count >= SEND_CALM_LO && sent_count < SEND_CALM_HI) ||
                     $urandom_range(0, 99) >= 25))
                begin
                    next_req = pending_requests.pop_front();
                    in_valid      <= 1'b1;
                    in_byte       <= next_req.data;
                    end_of_stream <= next_req.eos;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver: random stalls, one long hold-off, one quiet stretch
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            rx_cycle <= rx_cycle + 1;
            if (rx_cycle >= HOLD_START && rx_cycle < HOLD_START + HOLD_LEN)
                out_ready <= 1'b0;
            else if (rx_cycle >= CALM_START && rx_cycle < CALM_END)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(0, 99) >= 25);
        end
    end

    // monitor: every accepted output byte against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_bytes.size() == 0)
                report_mismatch("unexpected byte", 8'h00, 1'b0);
            else
            begin
                want = expected_bytes.pop_front();
                if (out_byte !== want.data || last_of_run !== want.last)
                    report_mismatch("wrong field", want.data, want.last);
            end
        end
    end

    // stimulus and end of run
    initial
    begin
        // directed: field extremes, nul after a percent, line break pair, every flush
        queue_request(8'h00, 1'b0);
        queue_request(8'hFF, 1'b0);
        queue_request(PCT_CHAR, 1'b0);
        queue_request(8'h00, 1'b0);
        queue_text("%0d%0A", 1'b0);
        queue_text("%4", 1'b1);
        queue_text("%", 1'b1);
        queue_text("%0D", 1'b1);
        queue_text("%0D%", 1'b1);
        queue_text("%0D%0", 1'b1);

        // random fragments
        while (queued < RANDOM_ITEMS)
            queue_fragment();

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_requests.size() > 0 || in_valid || expected_bytes.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (expected_bytes.size() > 0)
            $display("%0d expected bytes never arrived", expected_bytes.size());
        if (mismatches == 0 && expected_bytes.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // watchdog
    initial
    begin
        #2000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
